// File: src/lrt_pkg.sv
package lrt_pkg;

    // Fixed-point layout of the pixel channels and the white-point register.
    localparam int FRAC_BITS = 16;
    localparam int CH_W      = 24;
    localparam int CFG_W     = 24;
    localparam int WEIGHT_W  = 16;

    // Rec.709 luminance weights in Q0.16; they sum to exactly one.
    localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

    localparam logic [CFG_W-1:0] INV_WHITE_SQ_RESET = 24'd33437;

    // Derived widths along the datapath.
    localparam int PROD_W = WEIGHT_W + CH_W;       // one weighted channel
    localparam int SUM_W  = PROD_W + 2;            // sum of three products
    localparam int LUM_W  = CH_W;                  // luminance
    localparam int MUL_W  = LUM_W + CFG_W;         // luminance times register
    localparam int DEN_W  = CH_W + 1;              // one plus luminance
    localparam int NUM_W  = LUM_W + CFG_W + 1;     // rounded dividend
    localparam int Q_W    = CFG_W + 1;             // scale ratio
    localparam int SC_W   = CH_W + Q_W;            // scaled channel
    localparam int RND_W  = SC_W + 1;              // scaled channel plus rounding

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
    } pixel_out_t;

endpackage

// File: src/lrt_div.sv
module lrt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        start,
    input  logic [lrt_pkg::NUM_W-1:0]   num,
    input  logic [lrt_pkg::DEN_W-1:0]   den,
    input  lrt_pkg::pixel_in_t          pix,
    output logic                        done,
    output logic [lrt_pkg::Q_W-1:0]     quot,
    output lrt_pkg::pixel_in_t          pix_held
);
    import lrt_pkg::*;

    // One restoring step per stage, most significant quotient bit first.
    // The caller guarantees that the quotient fits in Q_W bits, so the
    // upper part of the dividend is already below the divisor.
    logic [DEN_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]   low_reg   [Q_W];
    logic [Q_W-1:0]   quot_reg  [Q_W];
    logic [DEN_W-1:0] den_reg   [Q_W];
    pixel_in_t        pix_reg   [Q_W];
    logic             valid_reg [Q_W];

    genvar s;
    for (s = 0; s < Q_W; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_cur;
        logic [DEN_W-1:0] den_cur;
        logic [Q_W-1:0]   low_cur;
        logic [Q_W-1:0]   quot_cur;
        pixel_in_t        pix_cur;
        logic             valid_cur;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   quot_next;

        if (s == 0)
        begin : g_first
            assign rem_cur   = DEN_W'(num >> Q_W);
            assign low_cur   = num[Q_W-1:0];
            assign quot_cur  = '0;
            assign den_cur   = den;
            assign pix_cur   = pix;
            assign valid_cur = start;
        end
        else
        begin : g_rest
            assign rem_cur   = rem_reg[s-1];
            assign low_cur   = low_reg[s-1];
            assign quot_cur  = quot_reg[s-1];
            assign den_cur   = den_reg[s-1];
            assign pix_cur   = pix_reg[s-1];
            assign valid_cur = valid_reg[s-1];
        end

        assign trial     = {rem_cur, low_cur[Q_W-1-s]};
        assign diff      = trial - {1'b0, den_cur};
        assign ge        = (trial >= {1'b0, den_cur});
        assign rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign quot_next = {quot_cur[Q_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                low_reg[s]  <= low_cur;
                quot_reg[s] <= quot_next;
                den_reg[s]  <= den_cur;
                pix_reg[s]  <= pix_cur;
            end
        end
    end

    assign done     = valid_reg[Q_W-1];
    assign quot     = quot_reg[Q_W-1];
    assign pix_held = pix_reg[Q_W-1];

endmodule

// File: src/luminance_reinhard_tonemap.sv
// Extended Reinhard tonemapper driven by luminance, one HDR pixel per word.
// The src channel takes a word of red, green and blue in unsigned Q8.16; the
// dst channel returns the tonemapped word in the same format, saturated at
// the channel maximum. Every source word gives exactly one result word, in
// order. The cfg channel writes the reciprocal of the white point squared;
// it is always ready and should only be written while the pipeline is empty.
// From src acceptance to dst_valid: four stages for luminance and the
// dividend, 25 ratio divider stages (one quotient bit each) and two stages
// for scaling and saturation. Unless dst stalls, throughput is one word per
// cycle, set by the fully pipelined divider and multipliers.
// Reset empties the pipeline and restores the white-point register to the
// value for a white point of 1.4. When the receiver holds dst_ready low with
// a word waiting, the whole pipeline freezes in place and src_ready falls;
// nothing is lost or repeated, and src_ready is high again in the cycle in
// which the waiting word is taken.
module luminance_reinhard_tonemap (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_ready,
    input  lrt_pkg::pixel_in_t            src_word,
    output logic                          dst_valid,
    input  logic                          dst_ready,
    output lrt_pkg::pixel_out_t           dst_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lrt_pkg::CFG_W-1:0]     cfg_word
);
    import lrt_pkg::*;

    localparam logic [SUM_W-1:0] LUM_HALF  = SUM_W'(1) << (WEIGHT_W - 1);
    localparam logic [DEN_W-1:0] DEN_ONE   = DEN_W'(1) << FRAC_BITS;
    localparam logic [NUM_W-1:0] NUM_ONE   = NUM_W'(1) << (2 * FRAC_BITS);
    localparam logic [Q_W-1:0]   RATIO_ONE = Q_W'(1) << FRAC_BITS;
    localparam logic [RND_W-1:0] SC_HALF   = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic [RND_W-1:0] CH_MAX    = RND_W'({CH_W{1'b1}});

    // The white-point register. The user must see that it is only written while the
    // pipeline is empty, so the multiplier stage may read it directly; the block does not enforce it.
    logic [CFG_W-1:0] iws_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iws_reg <= INV_WHITE_SQ_RESET;
        end
        else if (cfg_valid)
        begin
            iws_reg <= cfg_word;
        end
    end

    // A single advance signal moves every stage at once. The pipeline only
    // holds when a finished word is waiting and the receiver is not taking it.
    logic en;
    logic dst_valid_reg;

    assign en        = !dst_valid_reg || dst_ready;
    assign src_ready = en;

    // Stage 1: the three weighted channel products.
    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_prod_r_reg;
    logic [PROD_W-1:0] s1_prod_g_reg;
    logic [PROD_W-1:0] s1_prod_b_reg;
    pixel_in_t         s1_pix_reg;

    // Stage 2: luminance, rounded half up to Q8.16.
    logic              s2_valid_reg;
    logic [LUM_W-1:0]  s2_lum_reg;
    pixel_in_t         s2_pix_reg;
    logic [SUM_W-1:0]  lum_sum;

    // Stage 3: luminance times the register, and the divisor 1 + L.
    logic              s3_valid_reg;
    logic [MUL_W-1:0]  s3_mul_reg;
    logic [DEN_W-1:0]  s3_den_reg;
    pixel_in_t         s3_pix_reg;

    // Stage 4: the dividend with half the divisor added for rounding.
    logic              s4_valid_reg;
    logic [NUM_W-1:0]  s4_num_reg;
    logic [DEN_W-1:0]  s4_den_reg;
    pixel_in_t         s4_pix_reg;

    assign lum_sum = SUM_W'(s1_prod_r_reg) + SUM_W'(s1_prod_g_reg)
                   + SUM_W'(s1_prod_b_reg) + LUM_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_r_reg <= PROD_W'(W_RED)   * PROD_W'(src_word.red_in);
            s1_prod_g_reg <= PROD_W'(W_GREEN) * PROD_W'(src_word.green_in);
            s1_prod_b_reg <= PROD_W'(W_BLUE)  * PROD_W'(src_word.blue_in);
            s1_pix_reg    <= src_word;

            s2_lum_reg    <= LUM_W'(lum_sum >> WEIGHT_W);
            s2_pix_reg    <= s1_pix_reg;

            s3_mul_reg    <= MUL_W'(s2_lum_reg) * MUL_W'(iws_reg);
            s3_den_reg    <= DEN_ONE + DEN_W'(s2_lum_reg);
            s3_pix_reg    <= s2_pix_reg;

            s4_num_reg    <= NUM_ONE + NUM_W'(s3_mul_reg) + NUM_W'(s3_den_reg >> 1);
            s4_den_reg    <= s3_den_reg;
            s4_pix_reg    <= s3_pix_reg;
        end
    end

    // The ratio (1 + L*inv_white_sq) / (1 + L) never exceeds the larger of
    // one and the register, so it fits the quotient width of the divider.
    logic            div_done;
    logic [Q_W-1:0]  ratio;
    pixel_in_t       div_pix;

    lrt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .start    (s4_valid_reg),
        .num      (s4_num_reg),
        .den      (s4_den_reg),
        .pix      (s4_pix_reg),
        .done     (div_done),
        .quot     (ratio),
        .pix_held (div_pix)
    );

    // Scaling stage: each channel times the ratio, three multipliers side by
    // side.
    logic             sc_valid_reg;
    logic [SC_W-1:0]  sc_r_reg;
    logic [SC_W-1:0]  sc_g_reg;
    logic [SC_W-1:0]  sc_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg  <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sc_valid_reg  <= div_done;
            dst_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_r_reg <= SC_W'(div_pix.red_in)   * SC_W'(ratio);
            sc_g_reg <= SC_W'(div_pix.green_in) * SC_W'(ratio);
            sc_b_reg <= SC_W'(div_pix.blue_in)  * SC_W'(ratio);
        end
    end

    // Output stage: drop the fraction of the ratio with rounding half up and
    // clamp to the largest value the channel can hold.
    function automatic logic [CH_W-1:0] round_sat(input logic [SC_W-1:0] prod);
        logic [RND_W-1:0] shifted;
        shifted = (RND_W'(prod) + SC_HALF) >> FRAC_BITS;
        return (shifted > CH_MAX) ? {CH_W{1'b1}} : shifted[CH_W-1:0];
    endfunction

    pixel_out_t dst_word_reg;
    pixel_out_t dst_word_next;

    always_comb
    begin
        dst_word_next.red_out   = round_sat(sc_r_reg);
        dst_word_next.green_out = round_sat(sc_g_reg);
        dst_word_next.blue_out  = round_sat(sc_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dst_word_reg <= dst_word_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

`ifndef ASSERT_OFF
    // The divider needs the upper part of the dividend below the divisor,
    // otherwise the quotient would not fit its width.
    assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> ((s4_num_reg >> Q_W) < NUM_W'(s4_den_reg)))
        else $error("dividend too large for the ratio divider");

    // The ratio is a weighted mean of one and the register.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((ratio <= Q_W'(iws_reg)) || (ratio <= RATIO_ONE)))
        else $error("tonemap ratio out of range");

    // While the pipeline holds, no stage gains or loses a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg,
                         div_done, sc_valid_reg, dst_valid_reg}))
        else $error("pipeline occupancy changed during a stall");

    // A stall only arises with a word waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !src_ready |-> (dst_valid && !dst_ready))
        else $error("source held off without a waiting result");
`endif

endmodule

// File: tb/tonemap_checker.sv
`timescale 1ns / 100ps

module tonemap_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      src_valid,
    input  logic                      src_ready,
    input  lrt_pkg::pixel_in_t        src_word,
    input  logic                      dst_valid,
    input  logic                      dst_ready,
    input  lrt_pkg::pixel_out_t       dst_word,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [lrt_pkg::CFG_W-1:0] cfg_word,
    output int                        pending_pixels,
    output int                        mismatch_count
);

    import lrt_pkg::*;

    // Rec.709 weights in Q0.16 and the Q8.16 layout, kept apart from the package.
    localparam logic [63:0] LUMA_RED   = 64'd13933;
    localparam logic [63:0] LUMA_GREEN = 64'd46871;
    localparam logic [63:0] LUMA_BLUE  = 64'd4732;
    localparam int          FRAC       = 16;
    localparam logic [63:0] UNITY      = 64'd1 << FRAC;
    localparam logic [CFG_W-1:0] WHITE_SQ_DEFAULT = 24'd33437;

    logic [CFG_W-1:0] white_recip_sq = WHITE_SQ_DEFAULT;
    pixel_out_t       expected_pixels[$];
    pixel_out_t       want;
    logic             wrong;

    function automatic logic [CH_W-1:0] scale_channel(logic [CH_W-1:0] c, logic [63:0] ratio);
        logic [63:0] v;
        v = (64'(c) * ratio + (UNITY >> 1)) >> FRAC;
        if (v > 64'({CH_W{1'b1}}))
            return {CH_W{1'b1}};
        return v[CH_W-1:0];
    endfunction

    // Scale every channel by (1 + L*inv_white_sq) / (1 + L), rounded half up.
    function automatic pixel_out_t reinhard_pixel(pixel_in_t p, logic [CFG_W-1:0] inv_sq);
        logic [63:0] lum;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] ratio;
        pixel_out_t  o;
        lum = (LUMA_RED * 64'(p.red_in) + LUMA_GREEN * 64'(p.green_in)
               + LUMA_BLUE * 64'(p.blue_in) + 64'd32768) >> 16;
        num = (64'd1 << (2 * FRAC)) + lum * 64'(inv_sq);
        den = UNITY + lum;
        ratio = (num + (den >> 1)) / den;
        o.red_out   = scale_channel(p.red_in, ratio);
        o.green_out = scale_channel(p.green_in, ratio);
        o.blue_out  = scale_channel(p.blue_in, ratio);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_recip_sq = WHITE_SQ_DEFAULT;
            expected_pixels.delete();
            pending_pixels = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                white_recip_sq = cfg_word;

            // Results are retired before new words are queued, so a result can
            // never be matched against a word accepted on the same edge.
            if (dst_valid && dst_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h %h %h", dst_word.red_out,
                                 dst_word.green_out, dst_word.blue_out);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    wrong = (dst_word.red_out !== want.red_out)
                          || (dst_word.green_out !== want.green_out)
                          || (dst_word.blue_out !== want.blue_out);
                    if (wrong)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result word mismatch: expected %h %h %h, got %h %h %h",
                                     want.red_out, want.green_out, want.blue_out,
                                     dst_word.red_out, dst_word.green_out, dst_word.blue_out);
                    end
                end
            end

            if (src_valid && src_ready)
                expected_pixels.insert(expected_pixels.size(),
                                       reinhard_pixel(src_word, white_recip_sq));

            pending_pixels = expected_pixels.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

// Top level of the tonemapper testbench. It generates the clock and reset,
// drives the source and configuration channels, and throttles the result
// channel. All prediction and comparison lives in the checker instantiated
// beside the block; this module only reads the checker's count of words in
// flight and its mismatch count, and gives the verdict at the end.
module tb;

    import lrt_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int RANDOM_FIRST  = 200;
    localparam int RANDOM_PHASE  = 200;
    localparam int PHASES        = 7;
    localparam int DRAIN_CYCLES  = 40;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             src_valid = 1'b0;
    logic             src_ready;
    pixel_in_t        src_word  = '0;
    logic             dst_valid;
    logic             dst_ready = 1'b0;
    pixel_out_t       dst_word;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_word  = '0;

    int pending_pixels;
    int mismatch_count;
    int cycle_count = 0;
    int rx_hold     = 0;
    bit calm        = 1'b0;

    luminance_reinhard_tonemap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_word  (dst_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_word  (cfg_word)
    );

    tonemap_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_ready      (src_ready),
        .src_word       (src_word),
        .dst_valid      (dst_valid),
        .dst_ready      (dst_ready),
        .dst_word       (dst_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_word       (cfg_word),
        .pending_pixels (pending_pixels),
        .mismatch_count (mismatch_count)
    );

    always #4 clk = ~clk;

    // Every so often the traffic switches between a calm stretch, in which
    // neither side idles, and the normal mix of short and long gaps.
    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm <= ($urandom_range(0, 3) == 0);
        end
    end

    // Length of an idle gap: usually none, often a few cycles, rarely long.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic pixel_in_t px(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                     logic [CH_W-1:0] b);
        pixel_in_t p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        return p;
    endfunction

    // Random pixels of several flavours: full range, near black (luminance
    // rounding to zero, one or two), a single bright channel, values around one,
    // values near the top of the range, and a wide spread of magnitudes.
    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                p = px(24'($urandom), 24'($urandom), 24'($urandom));
            4, 5:
                p = px(24'($urandom_range(0, 3)), 24'($urandom_range(0, 1)),
                       24'($urandom_range(0, 7)));
            6:
            begin
                p = '0;
                case ($urandom_range(0, 2))
                    0: p.red_in = 24'($urandom);
                    1: p.green_in = 24'($urandom);
                    default: p.blue_in = 24'($urandom);
                endcase
            end
            7:
                p = px(24'($urandom_range(0, 196608)), 24'($urandom_range(0, 196608)),
                       24'($urandom_range(0, 196608)));
            8:
                p = px(24'hFFFFFF - 24'($urandom_range(0, 255)),
                       24'hFFFFFF - 24'($urandom_range(0, 255)),
                       24'hFFFFFF - 24'($urandom_range(0, 255)));
            default:
                p = px(24'($urandom >> $urandom_range(8, 31)),
                       24'($urandom >> $urandom_range(8, 31)),
                       24'($urandom >> $urandom_range(8, 31)));
        endcase
        return p;
    endfunction

    // Offers one word on the source channel and returns at the edge where it
    // is taken. Valid is lowered only when a gap follows, so a word offered
    // straight after the previous one keeps valid high without a glitch.
    task automatic send_pixel(input pixel_in_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= p;
        do @(posedge clk); while (!src_ready);
    endtask

    // Stops offering words and waits until every result word has come back.
    // The count is read at the falling edge, when the checker has settled.
    task automatic drain_pipeline();
        src_valid <= 1'b0;
        do @(negedge clk); while (pending_pixels != 0);
    endtask

    task automatic write_white_point(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_word  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // The receiver holds dst_ready low for random stretches, so stalls land
    // on every stage of the pipeline and force src_ready to drop as well.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_ready <= 1'b0;
            rx_hold = 0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            dst_ready <= 1'b0;
        end
        else
        begin
            dst_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                rx_hold = pick_gap();
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] setting;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset white point: black, full white,
        // each channel alone at its maximum, tiny pixels whose luminance
        // rounds to zero or to one, unity, and alternating bit patterns.
        send_pixel(px(24'd0, 24'd0, 24'd0));
        send_pixel(px(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(px(24'hFFFFFF, 24'd0, 24'd0));
        send_pixel(px(24'd0, 24'hFFFFFF, 24'd0));
        send_pixel(px(24'd0, 24'd0, 24'hFFFFFF));
        send_pixel(px(24'd1, 24'd0, 24'd0));
        send_pixel(px(24'd0, 24'd0, 24'd1));
        send_pixel(px(24'd0, 24'd1, 24'd0));
        send_pixel(px(24'd1, 24'd1, 24'd1));
        send_pixel(px(24'd65536, 24'd65536, 24'd65536));
        send_pixel(px(24'hAAAAAA, 24'h555555, 24'hAAAAAA));
        send_pixel(px(24'h555555, 24'hAAAAAA, 24'h555555));
        send_pixel(px(24'h800000, 24'd0, 24'd0));
        send_pixel(px(24'hFFFFFF, 24'd0, 24'hFFFFFF));
        for (int i = 0; i < RANDOM_FIRST; i++)
            send_pixel(random_pixel());

        // Each phase drains the pipeline, writes a new white point and runs
        // a fresh batch. The settings cover the smallest and largest legal
        // values, zero (plain Reinhard), exactly one, the reset value again
        // and two random points.
        for (int s = 0; s < PHASES; s++)
        begin
            case (s)
                0: setting = 24'd1;
                1: setting = 24'hFFFFFF;
                2: setting = 24'd0;
                3: setting = 24'd65536;
                5: setting = 24'd33437;
                default: setting = 24'($urandom_range(1, 24'hFFFFFF));
            endcase
            drain_pipeline();
            write_white_point(setting);
            send_pixel(px(24'd0, 24'd0, 24'd0));
            send_pixel(px(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
            send_pixel(px(24'd1, 24'd0, 24'd0));
            send_pixel(px(24'd65536, 24'd65536, 24'd65536));
            for (int i = 0; i < RANDOM_PHASE; i++)
                send_pixel(random_pixel());
        end

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_pixels == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
